// ===== hw/rtl/tvnf_pkg.sv =====
`default_nettype none
package tvnf_pkg;

  localparam int POS_W      = 24;
  localparam int OUT_W      = 16;
  localparam int SEED_W     = 32;
  localparam int PERIOD_W   = 11;
  localparam int VAL_W      = 24;
  localparam int FADE_W     = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int DEF_OCTAVES       = 5;
  localparam int DEF_POS_FRAC_BITS = 8;

  // Lattice hash multipliers.
  localparam logic [SEED_W-1:0] K_X    = 32'd73856093;
  localparam logic [SEED_W-1:0] K_Y    = 32'd19349663;
  localparam logic [SEED_W-1:0] K_Z    = 32'd83492791;
  localparam logic [SEED_W-1:0] K_SEED = 32'd2654435761;
  localparam logic [SEED_W-1:0] K_MIX1 = 32'd2246822519;
  localparam logic [SEED_W-1:0] K_MIX2 = 32'd3266489917;
  localparam logic [SEED_W-1:0] SEED_STEP = 32'd31;

  // 3.0 in Q16, the constant term of the smoothstep polynomial.
  localparam logic [FADE_W+1:0] FADE_THREE = 18'd196608;

  localparam logic [SEED_W-1:0]   RST_SEED   = 32'd11;
  localparam logic [PERIOD_W-1:0] RST_PERIOD = 11'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_SEED   = 1'b0,
    REG_TILE_PERIOD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SEED_W-1:0]   seed;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tvnf_div_pipe.sv =====
`default_nettype none
module tvnf_div_pipe #(
  parameter int LANES = 1,
  parameter int NW    = 8,
  parameter int DW    = 4,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [LANES-1:0][NW-1:0]   num,
  input  logic [DW-1:0]              den,
  input  logic [SW-1:0]              side_in,
  output logic                       out_valid,
  output logic [LANES-1:0][NW-1:0]   quo,
  output logic [LANES-1:0][DW-1:0]   rem,
  output logic [SW-1:0]              side_out
);

  // Restoring division, one quotient bit per stage. The divisor is static.
  logic [NW-1:0]                     vld;
  logic [NW-1:0][LANES-1:0][NW-1:0]  num_q;
  logic [NW-1:0][LANES-1:0][NW-1:0]  quo_q;
  logic [NW-1:0][LANES-1:0][DW-1:0]  rem_q;
  logic [NW-1:0][SW-1:0]             side_q;

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic                      prev_vld;
    logic [LANES-1:0][NW-1:0]  prev_num;
    logic [LANES-1:0][NW-1:0]  prev_quo;
    logic [LANES-1:0][DW-1:0]  prev_rem;
    logic [SW-1:0]             prev_side;
    logic [LANES-1:0][DW:0]    trial;
    logic [LANES-1:0][NW-1:0]  nxt_quo;
    logic [LANES-1:0][DW-1:0]  nxt_rem;

    if (j == 0) begin : g_first
      assign prev_vld  = in_valid;
      assign prev_num  = num;
      assign prev_quo  = '0;
      assign prev_rem  = '0;
      assign prev_side = side_in;
    end else begin : g_rest
      assign prev_vld  = vld[j-1];
      assign prev_num  = num_q[j-1];
      assign prev_quo  = quo_q[j-1];
      assign prev_rem  = rem_q[j-1];
      assign prev_side = side_q[j-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = {prev_rem[l], prev_num[l][NW-1-j]};
        if (trial[l] >= {1'b0, den}) begin
          nxt_rem[l] = DW'(trial[l] - {1'b0, den});
          nxt_quo[l] = (prev_quo[l] << 1) | NW'(1);
        end else begin
          nxt_rem[l] = DW'(trial[l]);
          nxt_quo[l] = prev_quo[l] << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      num_q[j]  <= prev_num;
      quo_q[j]  <= nxt_quo;
      rem_q[j]  <= nxt_rem;
      side_q[j] <= prev_side;
    end
  end

  assign out_valid = vld[NW-1];
  assign quo       = quo_q[NW-1];
  assign rem       = rem_q[NW-1];
  assign side_out  = side_q[NW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/tvnf_hash.sv =====
`default_nettype none
module tvnf_hash import tvnf_pkg::*; (
  input  logic              clk,
  input  logic [SEED_W-1:0] mix_in,
  output logic [VAL_W-1:0]  value
);

  // Avalanche finish of the lattice hash; the m1 and m2 stages each hold one multiply, the output stage an xor-shift.
  logic [SEED_W-1:0] x1;
  logic [SEED_W-1:0] x2;
  logic [SEED_W-1:0] m1;
  logic [SEED_W-1:0] m2;

  assign x1 = mix_in ^ (mix_in >> 16);
  assign x2 = m1 ^ (m1 >> 13);

  always_ff @(posedge clk) begin
    m1    <= x1 * K_MIX1;
    m2    <= x2 * K_MIX2;
    value <= VAL_W'(m2 ^ (m2 >> 16));
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tvnf_cell.sv =====
`default_nettype none
module tvnf_cell import tvnf_pkg::*; #(
  parameter int PW   = POS_W + DEF_OCTAVES - 1,
  parameter int FRAC = DEF_POS_FRAC_BITS,
  parameter int AW   = VAL_W + DEF_OCTAVES,
  parameter int OCT  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  input  logic [2:0][PW-1:0]   in_pos,
  input  logic [AW-1:0]        in_acc,
  output logic                 out_valid,
  output logic [2:0][PW-1:0]   out_pos,
  output logic [AW-1:0]        out_acc
);

  localparam int IW     = PW - FRAC;
  localparam int SW     = AW + 3*PW + 3 + 3*FRAC;
  localparam int DEPTH  = 7;
  localparam int FDEPTH = 5;
  localparam int KW     = FADE_W + 2;
  localparam int FPW    = 2*FADE_W + KW;
  localparam logic [2:0][SEED_W-1:0] K_AXIS = {K_Z, K_Y, K_X};

  function automatic logic [VAL_W-1:0] blend(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b,
                                             input logic [FADE_W-1:0] s);
    logic signed [VAL_W:0]          diff;
    logic signed [VAL_W+FADE_W+1:0] prod;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, s});
    return VAL_W'(a + VAL_W'(prod >>> FADE_W));
  endfunction

  // Period and seed of this octave; both follow the static configuration.
  logic [PERIOD_W-1:0] p0;
  logic [PERIOD_W-1:0] p_sh;
  logic [PERIOD_W-1:0] period;
  logic [SEED_W-1:0]   seed_term;

  assign p0     = (cfg.period == '0) ? PERIOD_W'(1) : cfg.period;
  assign p_sh   = p0 >> OCT;
  assign period = (OCT == 0) ? p0 : ((p_sh < PERIOD_W'(2)) ? PERIOD_W'(2) : p_sh);

  always_ff @(posedge clk) begin
    seed_term <= (cfg.seed + SEED_W'(OCT) * SEED_STEP) * K_SEED;
  end

  // Split each coordinate into sign, cell magnitude and fraction.
  logic [2:0][IW-1:0]   ip;
  logic [2:0][IW-1:0]   mag;
  logic [2:0]           neg;
  logic [2:0][FRAC-1:0] frac;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ip[a]   = in_pos[a][PW-1:FRAC];
      neg[a]  = ip[a][IW-1];
      mag[a]  = neg[a] ? (IW'(0) - ip[a]) : ip[a];
      frac[a] = in_pos[a][FRAC-1:0];
    end
  end

  logic                        d_valid;
  logic [2:0][PERIOD_W-1:0]    d_rem;
  logic [SW-1:0]               d_side;
  logic [AW-1:0]               d_acc;
  logic [2:0][PW-1:0]          d_pos;
  logic [2:0]                  d_neg;
  logic [2:0][FRAC-1:0]        d_frac;

  tvnf_div_pipe #(
    .LANES (3),
    .NW    (IW),
    .DW    (PERIOD_W),
    .SW    (SW)
  ) u_wrap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .num       (mag),
    .den       (period),
    .side_in   ({in_acc, in_pos, neg, frac}),
    .out_valid (d_valid),
    .quo       (),
    .rem       (d_rem),
    .side_out  (d_side)
  );

  assign {d_acc, d_pos, d_neg, d_frac} = d_side;

  // Lattice corners and Q16 fraction.
  logic [2:0][PERIOD_W-1:0] c0n;
  logic [2:0][PERIOD_W-1:0] c1n;
  logic [2:0][FADE_W-1:0]   tn;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      c0n[a] = (d_neg[a] && d_rem[a] != '0) ? (period - d_rem[a]) : d_rem[a];
      c1n[a] = (c0n[a] + PERIOD_W'(1) == period) ? '0 : (c0n[a] + PERIOD_W'(1));
      tn[a]  = FADE_W'(d_frac[a]) << (FADE_W - FRAC);
    end
  end

  logic [DEPTH-1:0]                 vq;
  logic [DEPTH-1:0][AW-1:0]         accq;
  logic [DEPTH-1:0][2:0][PW-1:0]    posq;
  logic [2:0][PERIOD_W-1:0]         c0_1;
  logic [2:0][PERIOD_W-1:0]         c1_1;
  logic [2:0][FADE_W-1:0]           t1;
  logic [2:0][SEED_W-1:0]           prod0;
  logic [2:0][SEED_W-1:0]           prod1;
  logic [2:0][2*FADE_W-1:0]         tt2;
  logic [2:0][KW-1:0]               kk2;
  logic [2:0][FPW-1:0]              fprod;
  logic [FDEPTH-1:0][2:0][FADE_W-1:0] fadeq;
  logic [7:0][SEED_W-1:0]           mix;
  logic [7:0][VAL_W-1:0]            h;
  logic [3:0][VAL_W-1:0]            lerp_x;
  logic [1:0][VAL_W-1:0]            lerp_y;

  // Corner index: bit 0 picks x1, bit 1 picks y1, bit 2 picks z1.
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      mix[c] = (((c & 1) != 0) ? prod1[0] : prod0[0]) ^
               (((c & 2) != 0) ? prod1[1] : prod0[1]) ^
               (((c & 4) != 0) ? prod1[2] : prod0[2]) ^ seed_term;
    end
    for (int a = 0; a < 3; a++) begin
      fprod[a] = FPW'(tt2[a]) * FPW'(kk2[a]);
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_corner
    tvnf_hash u_hash (
      .clk    (clk),
      .mix_in (mix[c]),
      .value  (h[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vq        <= '0;
      out_valid <= 1'b0;
    end else begin
      vq        <= {vq[DEPTH-2:0], d_valid};
      out_valid <= vq[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    accq[0] <= d_acc;
    posq[0] <= d_pos;
    for (int i = 1; i < DEPTH; i++) begin
      accq[i] <= accq[i-1];
      posq[i] <= posq[i-1];
    end
    for (int a = 0; a < 3; a++) begin
      c0_1[a]     <= c0n[a];
      c1_1[a]     <= c1n[a];
      t1[a]       <= tn[a];
      prod0[a]    <= SEED_W'(c0_1[a]) * K_AXIS[a];
      prod1[a]    <= SEED_W'(c1_1[a]) * K_AXIS[a];
      tt2[a]      <= (2*FADE_W)'(t1[a]) * (2*FADE_W)'(t1[a]);
      kk2[a]      <= FADE_THREE - KW'({t1[a], 1'b0});
      fadeq[0][a] <= fprod[a][3*FADE_W-1:2*FADE_W];
      out_pos[a]  <= posq[DEPTH-1][a] << 1;
    end
    for (int i = 1; i < FDEPTH; i++) begin
      fadeq[i] <= fadeq[i-1];
    end
    for (int j = 0; j < 4; j++) begin
      lerp_x[j] <= blend(h[2*j], h[2*j+1], fadeq[2][0]);
    end
    for (int j = 0; j < 2; j++) begin
      lerp_y[j] <= blend(lerp_x[2*j], lerp_x[2*j+1], fadeq[3][1]);
    end
    out_acc <= (accq[DEPTH-1] << 1) + AW'(blend(lerp_y[0], lerp_y[1], fadeq[4][2]));
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tileable_value_noise_fbm.sv =====
// Channel  | Ports                              | Handshake
// ---------+------------------------------------+-------------------------------
// item in  | pos_x, pos_y, pos_z                | taken when start=1 and busy=0
// result   | noise_value                        | valid for one cycle with done
// config   | cfg_we, cfg_index, cfg_data        | written when cfg_we=1
//
// One item is taken every clock cycle; busy is high only during reset.
// Each result passes through the octave cells in turn, then through the
// y_num, q_val and noise_value registers. In each cell most of the delay
// comes from the bit-serial wrap of each coordinate by the octave period,
// one bit per stage, followed by the hashing, fade and blending stages.
// The final divide by 2^OCTAVES-1 is a reciprocal multiply.
// Reset is synchronous; it clears the valid pipeline and restores the two
// registers. The receiver cannot stall, so done is never held back.
`default_nettype none
module tileable_value_noise_fbm import tvnf_pkg::*; #(
  parameter int OCTAVES       = DEF_OCTAVES,
  parameter int POS_FRAC_BITS = DEF_POS_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  output logic                   done,
  output logic [OUT_W-1:0]       noise_value,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Positions grow by one bit per octave as they double along the chain.
  localparam int PW = POS_W + OCTAVES - 1;
  // The sum holds up to 2^OCTAVES-1 lattice values.
  localparam int AW = VAL_W + OCTAVES;
  // Sum times 65535 plus half the divisor.
  localparam int XW = AW + OUT_W + 1;
  // What is left after the 2^24 part of the divisor is shifted out.
  localparam int YW = XW - VAL_W;
  localparam logic [XW-1:0] HALF_D = XW'((1 << OCTAVES) - 1) << (VAL_W - 1);
  localparam logic [OCTAVES-1:0] WEIGHT_SUM = OCTAVES'((1 << OCTAVES) - 1);
  // Reciprocal of the weight sum. The shift is a multiple of OCTAVES, so the
  // rounding error of the reciprocal is below 2^OCTAVES, and the shift is
  // large enough that the quotient is exact for every YW-bit numerator.
  localparam int RSH = OCTAVES * ((2*OCTAVES + 17 + OCTAVES - 1) / OCTAVES);
  localparam int RW  = RSH - OCTAVES + 2;
  localparam int MW  = YW + RW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RSH) + 64'(WEIGHT_SUM) - 64'd1) / 64'(WEIGHT_SUM);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic [SEED_W-1:0]   hash_seed;
  logic [PERIOD_W-1:0] tile_period;
  cfg_t                cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_seed   <= RST_SEED;
      tile_period <= RST_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_HASH_SEED:   hash_seed   <= cfg_data[SEED_W-1:0];
        REG_TILE_PERIOD: tile_period <= cfg_data[PERIOD_W-1:0];
      endcase
    end
  end

  assign cfg.seed   = hash_seed;
  assign cfg.period = tile_period;

  // The pipeline never stalls; items are refused only while reset holds.
  assign busy = rst;

  logic [OCTAVES:0]                 link_valid;
  logic [OCTAVES:0][2:0][PW-1:0]    link_pos;
  logic [OCTAVES:0][AW-1:0]         link_acc;

  assign link_valid[0]  = start && !busy;
  assign link_pos[0][0] = PW'(pos_x);
  assign link_pos[0][1] = PW'(pos_y);
  assign link_pos[0][2] = PW'(pos_z);
  assign link_acc[0]    = '0;

  // One cell per octave. Each doubles the sum it receives and adds its own
  // octave, so the last cell delivers the weighted sum in Horner form.
  for (genvar k = 0; k < OCTAVES; k++) begin : g_octave
    tvnf_cell #(
      .PW   (PW),
      .FRAC (POS_FRAC_BITS),
      .AW   (AW),
      .OCT  (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cfg       (cfg),
      .in_valid  (link_valid[k]),
      .in_pos    (link_pos[k]),
      .in_acc    (link_acc[k]),
      .out_valid (link_valid[k+1]),
      .out_pos   (link_pos[k+1]),
      .out_acc   (link_acc[k+1])
    );
  end

  // Normalize: multiply by 65535 as a shift and subtract, add half the
  // divisor for rounding, then drop the 2^24 factor before dividing.
  logic [XW-1:0] scaled;
  logic [YW-1:0] y_num;
  logic          y_valid;

  assign scaled = (XW'(link_acc[OCTAVES]) << OUT_W) - XW'(link_acc[OCTAVES]) + HALF_D;

  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
    end else begin
      y_valid <= link_valid[OCTAVES];
    end
  end

  always_ff @(posedge clk) begin
    y_num <= scaled[XW-1:VAL_W];
  end

  // Divide by the weight sum with one multiply by its reciprocal.
  logic          q_valid;
  logic [YW-1:0] q_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      q_valid <= y_valid;
    end
  end

  always_ff @(posedge clk) begin
    q_val <= YW'((MW'(y_num) * MW'(RECIP)) >> RSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q_valid;
    end
  end

  // Saturate at full scale.
  always_ff @(posedge clk) begin
    if (q_val > YW'({OUT_W{1'b1}})) begin
      noise_value <= {OUT_W{1'b1}};
    end else begin
      noise_value <= q_val[OUT_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tvnf_checker.sv =====
`default_nettype none
module tvnf_checker import tvnf_pkg::*; #(
  parameter int OCTAVES       = DEF_OCTAVES,
  parameter int POS_FRAC_BITS = DEF_POS_FRAC_BITS
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int IW  = POS_W + OCTAVES - 1 - POS_FRAC_BITS;
  localparam int LAT = OCTAVES * (IW + 8) + 3;

  // Every accepted item produces exactly one result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted item gave no result at the expected cycle");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching accepted item");

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_no_stall: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind tileable_value_noise_fbm tvnf_checker #(
  .OCTAVES       (OCTAVES),
  .POS_FRAC_BITS (POS_FRAC_BITS)
) u_tvnf_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
`default_nettype wire
